>>> hdl/cbd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the chunked body decoder.
package cbd_pkg;

    localparam int SIZE_BITS_DEF = 31;
    localparam int TOTAL_W       = 31;
    localparam int Q_DEPTH       = 4;

    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_DONE = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         out_kind;
        logic [7:0]         out_byte;
        logic [TOTAL_W-1:0] total_bytes;
    } out_item_t;

    // Byte after classification by the front end.
    typedef struct packed {
        logic [7:0] data;
        logic       eoi;
        logic       is_hex;
        logic [3:0] hex_val;
        logic       is_blank;
        logic       is_lf;
        logic       is_minus;
    } cls_item_t;

endpackage

>>> hdl/cbd_fifo.sv
`timescale 1ns / 1ps
// Small register FIFO used between the decoder stages.
module cbd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW:0]      count_reg;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == (PW+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> hdl/cbd_front.sv
`timescale 1ns / 1ps
// Front end: classifies each incoming byte for the parser.
module cbd_front
    import cbd_pkg::*;
(
    input  in_item_t  in_item,
    output cls_item_t cls_item
);

    logic [7:0] b;

    assign b = in_item.in_byte;

    always_comb
    begin
        cls_item          = '0;
        cls_item.data     = b;
        cls_item.eoi      = in_item.end_of_input;
        cls_item.is_lf    = (b == 8'h0A);
        cls_item.is_minus = (b == 8'h2D);
        cls_item.is_blank = (b == 8'h20) || (b == 8'h09) || (b == 8'h0B)
                         || (b == 8'h0C) || (b == 8'h0D);
        if (b >= 8'h30 && b <= 8'h39)
        begin
            cls_item.is_hex  = 1'b1;
            cls_item.hex_val = 4'(b - 8'h30);
        end
        else if (b >= 8'h61 && b <= 8'h66)
        begin
            cls_item.is_hex  = 1'b1;
            cls_item.hex_val = 4'(b - 8'h57);
        end
        else if (b >= 8'h41 && b <= 8'h46)
        begin
            cls_item.is_hex  = 1'b1;
            cls_item.hex_val = 4'(b - 8'h37);
        end
    end

endmodule

>>> hdl/cbd_back.sv
`timescale 1ns / 1ps
// Back end: chunk parser state machine, one classified byte per cycle while the result queue has room.
module cbd_back
    import cbd_pkg::*;
#(
    parameter int SIZE_BITS = SIZE_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_empty,
    input  cls_item_t q_item,
    output logic      q_pop,
    input  logic      r_full,
    output logic      r_push,
    output out_item_t r_item
);

    localparam logic [2:0] PH_SIZE  = 3'd0;
    localparam logic [2:0] PH_DATA  = 3'd1;
    localparam logic [2:0] PH_TRAIL = 3'd2;
    localparam logic [2:0] PH_DONE  = 3'd3;
    localparam logic [2:0] PH_ERR   = 3'd4;

    logic [2:0]           phase_reg, phase_next;
    logic [SIZE_BITS-1:0] size_reg, size_next;
    logic                 digits_reg, digits_next;
    logic                 ended_reg, ended_next;
    logic [SIZE_BITS-1:0] remain_reg, remain_next;
    logic                 zero_reg, zero_next;
    logic                 started_reg, started_next;
    logic [TOTAL_W-1:0]   total_reg, total_next;

    logic [TOTAL_W:0]     total_sum;
    logic [SIZE_BITS-1:0] remain_dec;

    assign q_pop      = !q_empty && !r_full;
    assign total_sum  = {1'b0, total_reg} + (TOTAL_W+1)'(size_reg);
    assign remain_dec = (remain_reg != '0) ? remain_reg - 1'b1 : remain_reg;

    always_comb
    begin
        phase_next   = phase_reg;
        size_next    = size_reg;
        digits_next  = digits_reg;
        ended_next   = ended_reg;
        remain_next  = remain_reg;
        zero_next    = zero_reg;
        started_next = started_reg;
        total_next   = total_reg;
        r_push       = 1'b0;
        r_item       = '0;

        if (q_pop && phase_reg != PH_DONE && phase_reg != PH_ERR)
        begin
            if (q_item.eoi)
            begin
                r_push = 1'b1;
                if (phase_reg == PH_TRAIL && started_reg && zero_reg)
                begin
                    phase_next         = PH_DONE;
                    r_item.out_kind    = KIND_DONE;
                    r_item.total_bytes = total_reg;
                end
                else
                begin
                    phase_next      = PH_ERR;
                    r_item.out_kind = KIND_ERR;
                end
            end
            else
            begin
                unique case (phase_reg)
                    PH_SIZE:
                    begin
                        started_next = 1'b1;
                        if (q_item.is_lf)
                        begin
                            if (!digits_reg)
                            begin
                                phase_next      = PH_ERR;
                                r_push          = 1'b1;
                                r_item.out_kind = KIND_ERR;
                            end
                            else
                            begin
                                // end of size line: commit the chunk length
                                total_next   = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
                                remain_next  = size_reg;
                                zero_next    = (size_reg == '0);
                                phase_next   = (size_reg == '0) ? PH_TRAIL : PH_DATA;
                                size_next    = '0;
                                digits_next  = 1'b0;
                                ended_next   = 1'b0;
                                started_next = 1'b0;
                            end
                        end
                        else if (ended_reg)
                        begin
                            // extension text, ignored up to LF
                        end
                        else if (!digits_reg && q_item.is_blank)
                        begin
                        end
                        else if (!digits_reg && q_item.is_minus)
                        begin
                            phase_next      = PH_ERR;
                            r_push          = 1'b1;
                            r_item.out_kind = KIND_ERR;
                        end
                        else if (!q_item.is_hex)
                        begin
                            if (!digits_reg)
                            begin
                                phase_next      = PH_ERR;
                                r_push          = 1'b1;
                                r_item.out_kind = KIND_ERR;
                            end
                            else
                            begin
                                ended_next = 1'b1;
                            end
                        end
                        else if (size_reg[SIZE_BITS-1 -: 4] != 4'd0)
                        begin
                            // another digit would overflow the size field
                            phase_next      = PH_ERR;
                            r_push          = 1'b1;
                            r_item.out_kind = KIND_ERR;
                        end
                        else
                        begin
                            size_next   = {size_reg[SIZE_BITS-5:0], q_item.hex_val};
                            digits_next = 1'b1;
                        end
                    end
                    PH_DATA:
                    begin
                        remain_next = remain_dec;
                        if (remain_dec == '0)
                        begin
                            phase_next   = PH_TRAIL;
                            started_next = 1'b0;
                        end
                        r_push          = 1'b1;
                        r_item.out_kind = KIND_DATA;
                        r_item.out_byte = q_item.data;
                    end
                    PH_TRAIL:
                    begin
                        started_next = 1'b1;
                        if (q_item.is_lf)
                        begin
                            if (zero_reg)
                            begin
                                phase_next         = PH_DONE;
                                r_push             = 1'b1;
                                r_item.out_kind    = KIND_DONE;
                                r_item.total_bytes = total_reg;
                            end
                            else
                            begin
                                phase_next   = PH_SIZE;
                                started_next = 1'b0;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_SIZE;
            size_reg    <= '0;
            digits_reg  <= 1'b0;
            ended_reg   <= 1'b0;
            remain_reg  <= '0;
            zero_reg    <= 1'b0;
            started_reg <= 1'b0;
            total_reg   <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            size_reg    <= size_next;
            digits_reg  <= digits_next;
            ended_reg   <= ended_next;
            remain_reg  <= remain_next;
            zero_reg    <= zero_next;
            started_reg <= started_next;
            total_reg   <= total_next;
        end
    end

endmodule

>>> hdl/chunked_body_decoder.sv
`timescale 1ns / 1ps
// Top level of the chunked transfer body decoder.
// Decodes a chunk-encoded body one byte per item, one item per clock while
// no queue is full. Bytes are classified on entry into a four-entry queue;
// the parser drains it one byte per cycle into a four-entry result queue
// while that has room, so input and output stall independently. A byte is
// registered in the input queue and its result in the result queue on the
// way out. Payload bytes come out as data items; a zero-size chunk followed by
// its closing line gives a done item with the saturated byte count. Any format
// fault or early end of input gives one error item and silence until reset.
module chunked_body_decoder
    import cbd_pkg::*;
#(
    parameter int SIZE_BITS = SIZE_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  in_item_t  in_item,
    input  logic      pop,
    output logic      empty,
    output out_item_t out_item
);

    localparam int CLS_W = $bits(cls_item_t);
    localparam int OUT_W = $bits(out_item_t);

    cls_item_t cls_in;
    cls_item_t cls_out;
    logic      q_empty;
    logic      q_pop;
    logic      r_full;
    logic      r_push;
    out_item_t r_item;

    cbd_front u_front (
        .in_item  (in_item),
        .cls_item (cls_in)
    );

    cbd_fifo #(
        .WIDTH (CLS_W),
        .DEPTH (Q_DEPTH)
    ) u_cls_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (cls_in),
        .full    (full),
        .rd_en   (q_pop),
        .rd_data (cls_out),
        .empty   (q_empty)
    );

    cbd_back #(
        .SIZE_BITS (SIZE_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_item  (cls_out),
        .q_pop   (q_pop),
        .r_full  (r_full),
        .r_push  (r_push),
        .r_item  (r_item)
    );

    cbd_fifo #(
        .WIDTH (OUT_W),
        .DEPTH (Q_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (r_push),
        .wr_data (r_item),
        .full    (r_full),
        .rd_en   (pop),
        .rd_data (out_item),
        .empty   (empty)
    );

endmodule

>>> sim/chunked_body_decoder_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the chunked body decoder: random chunked bodies, queue handshakes.
module chunked_body_decoder_tb;
    import cbd_pkg::*;

    localparam int          SIZE_W    = SIZE_BITS_DEF;
    localparam int          ITEMS     = 1950;
    localparam int          WATCHDOG  = 4000;
    localparam int          DRAIN     = 12;
    localparam int          HOLD_LEN  = 300;
    localparam logic [7:0]  CH_LF     = 8'h0A;
    localparam logic [7:0]  CH_CR     = 8'h0D;
    localparam logic [7:0]  CH_MINUS  = 8'h2D;
    localparam logic [63:0] SIZE_MAX  = (64'd1 << SIZE_W) - 64'd1;
    localparam logic [30:0] TOTAL_MAX = 31'h7FFF_FFFF;

    localparam logic [2:0]  P_SIZE    = 3'd0;
    localparam logic [2:0]  P_DATA    = 3'd1;
    localparam logic [2:0]  P_TRAIL   = 3'd2;
    localparam logic [2:0]  P_DONE    = 3'd3;
    localparam logic [2:0]  P_ERR     = 3'd4;

    logic      clk   = 1'b0;
    logic      rst_n = 1'b0;
    logic      push  = 1'b0;
    logic      pop   = 1'b0;
    in_item_t  in_item = '0;
    logic      full;
    logic      empty;
    out_item_t out_item;

    in_item_t  body_q[$];
    out_item_t decoded_q[$];
    int        n_in;
    int        n_mismatch;
    int        idle_cycles;
    int        hold_left;
    bit        hold_used;

    // decoder state as the predictor sees it
    logic [2:0]   ph;
    logic [30:0]  size_accum;
    logic         digits_seen;
    logic         number_ended;
    logic [30:0]  remaining;
    logic         last_zero;
    logic         line_started;
    logic [30:0]  byte_total;

    chunked_body_decoder i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .in_item  (in_item),
        .pop      (pop),
        .empty    (empty),
        .out_item (out_item)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        n_mismatch++;
    endtask

    task automatic decode_byte(input in_item_t it);
        logic [7:0]  b;
        logic [63:0] nxt;
        logic [63:0] sum;
        int          d;
        bit          emit;
        bit          bad;
        out_item_t   r;
        b    = it.in_byte;
        emit = 1'b0;
        bad  = 1'b0;
        r    = '0;
        if (ph == P_DONE || ph == P_ERR)
        begin
            // sticky: nothing more until reset
        end
        else if (it.end_of_input)
        begin
            if (ph == P_TRAIL && line_started && last_zero)
            begin
                ph            = P_DONE;
                emit          = 1'b1;
                r.out_kind    = KIND_DONE;
                r.total_bytes = byte_total;
            end
            else
                bad = 1'b1;
        end
        else if (ph == P_SIZE)
        begin
            line_started = 1'b1;
            if (b == CH_LF)
            begin
                if (!digits_seen)
                    bad = 1'b1;
                else
                begin
                    sum          = 64'(byte_total) + 64'(size_accum);
                    byte_total   = (sum > 64'(TOTAL_MAX)) ? TOTAL_MAX : sum[30:0];
                    remaining    = size_accum;
                    last_zero    = (size_accum == '0);
                    ph           = last_zero ? P_TRAIL : P_DATA;
                    size_accum   = '0;
                    digits_seen  = 1'b0;
                    number_ended = 1'b0;
                    line_started = 1'b0;
                end
            end
            else if (number_ended)
            begin
                // extension text, dropped
            end
            else if (!digits_seen && b inside {8'h20, 8'h09, 8'h0B, 8'h0C, 8'h0D})
            begin
                // leading blank
            end
            else if (!digits_seen && b == CH_MINUS)
                bad = 1'b1;
            else
            begin
                if (b >= "0" && b <= "9")
                    d = b - "0";
                else if (b >= "a" && b <= "f")
                    d = b - "a" + 10;
                else if (b >= "A" && b <= "F")
                    d = b - "A" + 10;
                else
                    d = -1;
                if (d < 0)
                begin
                    if (!digits_seen)
                        bad = 1'b1;
                    else
                        number_ended = 1'b1;
                end
                else
                begin
                    nxt = (64'(size_accum) << 4) + 64'(d);
                    if (nxt > SIZE_MAX)
                        bad = 1'b1;
                    else
                    begin
                        size_accum  = nxt[30:0];
                        digits_seen = 1'b1;
                    end
                end
            end
        end
        else if (ph == P_DATA)
        begin
            if (remaining != '0)
                remaining = remaining - 31'd1;
            if (remaining == '0)
            begin
                ph           = P_TRAIL;
                line_started = 1'b0;
            end
            emit       = 1'b1;
            r.out_kind = KIND_DATA;
            r.out_byte = b;
        end
        else
        begin
            line_started = 1'b1;
            if (b == CH_LF)
            begin
                if (last_zero)
                begin
                    ph            = P_DONE;
                    emit          = 1'b1;
                    r.out_kind    = KIND_DONE;
                    r.total_bytes = byte_total;
                end
                else
                begin
                    ph           = P_SIZE;
                    line_started = 1'b0;
                end
            end
        end
        if (bad)
        begin
            ph         = P_ERR;
            emit       = 1'b1;
            r          = '0;
            r.out_kind = KIND_ERR;
        end
        if (emit)
            decoded_q.push_back(r);
    endtask

    task automatic add_byte(input logic [7:0] b);
        body_q.push_back(in_item_t'{in_byte: b, end_of_input: 1'b0});
    endtask

    task automatic add_eoi();
        body_q.push_back(in_item_t'{in_byte: 8'($urandom_range(255)), end_of_input: 1'b1});
    endtask

    // size line: optional blanks and leading zeros, mixed-case hex, optional extension
    task automatic add_size_line(input int unsigned sz);
        logic [7:0] blanks [5];
        logic [7:0] e;
        int         nd;
        int         v;
        blanks = '{8'h20, 8'h09, 8'h0B, 8'h0C, 8'h0D};
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 2)) add_byte(blanks[$urandom_range(4)]);
        if ($urandom_range(4) == 0)
            repeat ($urandom_range(1, 2)) add_byte("0");
        nd = 1;
        while (nd < 8 && (sz >> (4 * nd)) != 0)
            nd++;
        for (int i = nd - 1; i >= 0; i--)
        begin
            v = (sz >> (4 * i)) & 15;
            if (v < 10)
                add_byte(8'("0" + v));
            else
                add_byte(8'(($urandom_range(1) ? "A" : "a") + v - 10));
        end
        if ($urandom_range(9) < 3)
        begin
            add_byte($urandom_range(1) ? ";" : " ");
            repeat ($urandom_range(6))
            begin
                e = 8'($urandom_range(255));
                add_byte(e == CH_LF ? "=" : e);
            end
        end
        if ($urandom_range(9) < 8)
            add_byte(CH_CR);
        add_byte(CH_LF);
    endtask

    task automatic add_trailer();
        logic [7:0] e;
        int         r;
        r = $urandom_range(99);
        if (r < 10)
            add_byte(CH_LF);
        else
        begin
            if (r >= 95)
                repeat ($urandom_range(1, 4))
                begin
                    e = 8'($urandom_range(255));
                    add_byte(e == CH_LF ? "." : e);
                end
            add_byte(CH_CR);
            add_byte(CH_LF);
        end
    endtask

    // sender
    always @(negedge clk)
    begin : drive_proc
        int mode;
        int pct;
        mode = (n_in / 250) % 4;
        pct  = (mode == 1) ? 47 : (mode == 3) ? 12 : 0;
        if (rst_n && body_q.size() != 0 && $urandom_range(99) >= pct)
        begin
            push    <= 1'b1;
            in_item <= body_q[0];
        end
        else
            push <= 1'b0;
    end

    // receiver, with one long hold-off to back the block up
    always @(negedge clk)
    begin : sink_proc
        int mode;
        int pct;
        mode = (n_in / 250) % 4;
        pct  = (mode == 2) ? 47 : (mode == 3) ? 12 : 0;
        if (hold_left > 0)
        begin
            hold_left--;
            pop <= 1'b0;
        end
        else if (!hold_used && n_in >= 150)
        begin
            hold_used = 1'b1;
            hold_left = HOLD_LEN;
            pop <= 1'b0;
        end
        else
            pop <= rst_n && ($urandom_range(99) >= pct);
    end

    always @(posedge clk)
    begin : check_proc
        bit        moved;
        out_item_t want;
        moved = 1'b0;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                moved = 1'b1;
                if (decoded_q.size() == 0)
                    report_mismatch($sformatf("unexpected result kind=%0d byte=%02h total=%0d",
                        out_item.out_kind, out_item.out_byte, out_item.total_bytes));
                else
                begin
                    want = decoded_q.pop_front();
                    if (out_item.out_kind !== want.out_kind)
                        report_mismatch($sformatf("out_kind %0d, want %0d",
                            out_item.out_kind, want.out_kind));
                    if (out_item.out_byte !== want.out_byte)
                        report_mismatch($sformatf("out_byte %02h, want %02h",
                            out_item.out_byte, want.out_byte));
                    if (out_item.total_bytes !== want.total_bytes)
                        report_mismatch($sformatf("total_bytes %0d, want %0d",
                            out_item.total_bytes, want.total_bytes));
                end
            end
            if (push && !full)
            begin
                moved = 1'b1;
                decode_byte(in_item);
                void'(body_q.pop_front());
                n_in++;
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG)
            begin
                $display("timeout: no handshake for %0d cycles", WATCHDOG);
                $display("** chunked_body_decoder: FAILED **");
                $finish;
            end
        end
    end

    initial
    begin : stim_proc
        logic [7:0]  intro [22];
        logic [7:0]  nodig [4];
        int unsigned sz;
        int          r;
        ph           = P_SIZE;
        size_accum   = '0;
        digits_seen  = 1'b0;
        number_ended = 1'b0;
        remaining    = '0;
        last_zero    = 1'b0;
        line_started = 1'b0;
        byte_total   = '0;

        // all blank kinds, extension, then data bytes at the extremes and LF/CR inside data
        intro = '{8'h20, 8'h09, 8'h0B, 8'h0C, 8'h0D, "a", ";", "Z", CH_CR, CH_LF,
                  8'h00, 8'hFF, CH_LF, CH_MINUS, "0", 8'h80, 8'h7F, 8'h55, 8'hAA, CH_CR,
                  CH_CR, CH_LF};
        foreach (intro[i])
            add_byte(intro[i]);

        while (body_q.size() < ITEMS)
        begin
            r = $urandom_range(99);
            if (r < 70)
                sz = $urandom_range(1, 16);
            else if (r < 95)
                sz = $urandom_range(17, 64);
            else
                sz = $urandom_range(65, 300);
            add_size_line(sz);
            repeat (sz) add_byte(8'($urandom_range(255)));
            add_trailer();
        end

        // one way of ending the body; the block is sticky after it
        nodig = '{CH_LF, "+", "g", ";"};
        case ($urandom_range(9))
            0:
            begin
                add_size_line(0);
                add_trailer();
            end
            1:
            begin
                // hex prefix reads as size zero
                add_byte("0");
                add_byte("x");
                add_byte("1");
                add_byte("A");
                add_byte(CH_CR);
                add_byte(CH_LF);
                add_trailer();
            end
            2:
            begin
                add_size_line(0);
                add_byte("X");
                add_eoi();
            end
            3:
            begin
                add_size_line(0);
                add_eoi();
            end
            4:
            begin
                add_byte(" ");
                add_byte(nodig[$urandom_range(3)]);
            end
            5:
            begin
                add_byte(" ");
                add_byte(CH_MINUS);
                add_byte("5");
            end
            6:
            begin
                add_byte($urandom_range(1) ? "F" : "8");
                repeat (7) add_byte("0");
            end
            7:
            begin
                add_byte("1");
                add_eoi();
            end
            8:
            begin
                // largest legal size, cut short
                add_size_line(32'h7FFF_FFFF);
                repeat (5) add_byte(8'($urandom_range(255)));
                add_eoi();
            end
            default:
                add_eoi();
        endcase
        add_eoi();
        repeat (6)
            body_q.push_back(in_item_t'{in_byte: 8'($urandom_range(255)),
                                        end_of_input: 1'($urandom_range(1))});

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (body_q.size() != 0 || decoded_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (decoded_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", decoded_q.size()));
        if (n_mismatch == 0)
            $display("** chunked_body_decoder: PASSED **");
        else
            $display("** chunked_body_decoder: FAILED **");
        $finish;
    end

endmodule
